### rtl/imu_angle_frame_filter_assert.svh
// Assertion macros for the angle frame filter.
// Each check is sampled on the rising edge of clk and is skipped while rst_n is low.
`ifndef IMU_ANGLE_FRAME_FILTER_ASSERT_SVH
`define IMU_ANGLE_FRAME_FILTER_ASSERT_SVH

// When the condition holds, the expectation must hold in the same cycle.
`define IAFF_ASSERT_NOW(label, cond, expect_now) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_now)) \
    else $error("iaff check failed");

// When the condition holds, the expectation must hold in the next cycle.
`define IAFF_ASSERT_NEXT(label, cond, expect_next) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
    else $error("iaff check failed");

`endif

### rtl/iaff_pkg.sv
package iaff_pkg;

  // Frame layout.
  localparam int BYTE_W        = 8;
  localparam int PAYLOAD_BYTES = 6;
  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_BYTE   = 8'h55;
  localparam int POS_W = 3;
  localparam logic [POS_W-1:0] POS_HEADER = 3'd0;
  localparam logic [POS_W-1:0] POS_TAIL   = 3'd7;

  // Angle and filter widths.
  localparam int ANGLE_W          = 16;
  localparam int SMOOTH_W         = 24;
  localparam int FILTER_FRAC_BITS = 8;
  localparam int ALPHA_W          = 9;
  localparam int TILT_W           = 15;
  localparam int LIMIT_W          = 16;
  localparam int TGT_W  = ANGLE_W + FILTER_FRAC_BITS;
  localparam int DIFF_W = ((TGT_W > SMOOTH_W) ? TGT_W : SMOOTH_W) + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;

  typedef logic signed [ANGLE_W-1:0]  angle_t;
  typedef logic signed [SMOOTH_W-1:0] smooth_t;

  // Result status codes.
  localparam logic [1:0] ST_ACCEPT   = 2'd0;
  localparam logic [1:0] ST_BAD_TAIL = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_JUMP     = 2'd3;

  // Configuration register map.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TILT_LIM   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_YAW_LIM    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TILT_JUMP  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_YAW_JUMP   = 3'd4;

  // Register values after reset.
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 9'd77;
  localparam logic [TILT_W-1:0]  TILT_LIM_RST  = 15'd18000;
  localparam logic [LIMIT_W-1:0] YAW_LIM_RST   = 16'd36000;
  localparam logic [LIMIT_W-1:0] TILT_JUMP_RST = 16'd9000;
  localparam logic [LIMIT_W-1:0] YAW_JUMP_RST  = 16'd18000;

endpackage

### rtl/iaff_in_if.sv
interface iaff_in_if;
  import iaff_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/iaff_out_if.sv
interface iaff_out_if;
  import iaff_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  angle_t     yaw_sample;
  angle_t     pitch_sample;
  angle_t     roll_sample;
  smooth_t    yaw_smoothed;
  smooth_t    pitch_smoothed;
  smooth_t    roll_smoothed;

  modport source (
    output valid, output frame_status,
    output yaw_sample, output pitch_sample, output roll_sample,
    output yaw_smoothed, output pitch_smoothed, output roll_smoothed,
    input ready
  );
  modport sink (
    input valid, input frame_status,
    input yaw_sample, input pitch_sample, input roll_sample,
    input yaw_smoothed, input pitch_smoothed, input roll_smoothed,
    output ready
  );
endinterface

### rtl/iaff_cfg_if.sv
interface iaff_cfg_if;
  import iaff_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

### rtl/imu_angle_frame_filter.sv
// Angle frame filter: takes one received serial byte per transaction, one per clock, and
// frames 8-byte packets (0xAA header, big-endian signed yaw, pitch, roll, 0x55 tail). A
// byte other than 0xAA at the header position is dropped. Each completed frame gives one
// result with a status (accepted, bad tail, angle out of range, jump too large), the
// decoded angles and the three smoothed angles; only accepted frames move the filters and
// the last accepted angles. The tail byte loads the frame register; when the output register
// is free, the frame passes through the checks and the three 10x25-bit filter multipliers
// into the output register. Input bytes are taken every cycle; only a frame waiting behind
// an unread result stalls the input. Configuration writes are always taken and should be
// made while no frame is in flight.
module imu_angle_frame_filter (
  input logic        clk,
  input logic        rst_n,
  iaff_cfg_if.sink   cfg_ch,
  iaff_in_if.sink    in_ch,
  iaff_out_if.source out_ch
);
  import iaff_pkg::*;

  `include "imu_angle_frame_filter_assert.svh"

  // Absolute value of a 17-bit signed number.
  function automatic logic [ANGLE_W:0] abs17(input logic signed [ANGLE_W:0] v);
    abs17 = v[ANGLE_W] ? (ANGLE_W+1)'(-v) : v;
  endfunction

  // One filter step with saturation to the smoothed range.
  function automatic smooth_t filt_step(input smooth_t f, input angle_t x,
                                        input logic [ALPHA_W-1:0] alpha);
    logic signed [DIFF_W-1:0] tgt;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] sum;
    logic [PROD_W-SMOOTH_W:0] top;
    tgt  = DIFF_W'(x) <<< FILTER_FRAC_BITS;
    diff = tgt - DIFF_W'(f);
    prod = PROD_W'($signed({1'b0, alpha})) * PROD_W'(diff);
    sum  = PROD_W'(f) + (prod >>> FILTER_FRAC_BITS);
    top  = sum[PROD_W-1:SMOOTH_W-1];
    if (top == '0 || top == '1) begin
      filt_step = sum[SMOOTH_W-1:0];
    end else if (sum[PROD_W-1]) begin
      filt_step = {1'b1, {(SMOOTH_W-1){1'b0}}};
    end else begin
      filt_step = {1'b0, {(SMOOTH_W-1){1'b1}}};
    end
  endfunction

  // Configuration registers.
  logic [ALPHA_W-1:0] alpha_r;
  logic [TILT_W-1:0]  tilt_lim_r;
  logic [LIMIT_W-1:0] yaw_lim_r;
  logic [LIMIT_W-1:0] tilt_jump_r;
  logic [LIMIT_W-1:0] yaw_jump_r;

  // Framing state.
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] pl_r [PAYLOAD_BYTES];

  // Frame register.
  logic   fr_valid_r, fr_valid_nxt;
  logic   fr_tail_ok_r;
  angle_t fr_ang_r [3];

  // Filter state.
  angle_t  last_r [3];
  smooth_t sm_r [3];

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r;
  angle_t     out_ang_r [3];
  smooth_t    out_sm_r [3];

  logic       in_acc;
  logic       out_free;
  logic       fire;
  logic       range_bad;
  logic       jump_bad;
  logic [1:0] status;
  logic [ANGLE_W:0] ang_abs [3];
  logic [ANGLE_W:0] jump_abs [3];
  smooth_t    sm_upd [3];

  // Handshakes.
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign fire         = fr_valid_r && out_free;
  assign in_ch.ready  = !fr_valid_r || out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // Configuration writes; addresses past the map are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= ALPHA_RST;
      tilt_lim_r  <= TILT_LIM_RST;
      yaw_lim_r   <= YAW_LIM_RST;
      tilt_jump_r <= TILT_JUMP_RST;
      yaw_jump_r  <= YAW_JUMP_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        CFG_ALPHA:     alpha_r     <= cfg_ch.wdata[ALPHA_W-1:0];
        CFG_TILT_LIM:  tilt_lim_r  <= cfg_ch.wdata[TILT_W-1:0];
        CFG_YAW_LIM:   yaw_lim_r   <= cfg_ch.wdata;
        CFG_TILT_JUMP: tilt_jump_r <= cfg_ch.wdata;
        CFG_YAW_JUMP:  yaw_jump_r  <= cfg_ch.wdata;
        default: begin
        end
      endcase
    end
  end

  // Byte position: wait for a header, then count payload bytes up to the tail.
  always_comb begin
    pos_nxt = pos_r;
    if (in_acc) begin
      if (pos_r == POS_HEADER) begin
        pos_nxt = (in_ch.rx_byte == HEADER_BYTE) ? POS_W'(1) : POS_HEADER;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // The frame register loads on the tail byte and empties when its result is stored.
  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (fire) begin
      fr_valid_nxt = 1'b0;
    end
    if (in_acc && pos_r == POS_TAIL) begin
      fr_valid_nxt = 1'b1;
    end
  end

  assign out_valid_nxt = fire || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_HEADER;
      fr_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      fr_valid_r  <= fr_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload bytes shift in; the oldest ends up at the top.
  always_ff @(posedge clk) begin
    if (in_acc && pos_r != POS_HEADER && pos_r != POS_TAIL) begin
      pl_r[0] <= in_ch.rx_byte;
      for (int i = 1; i < PAYLOAD_BYTES; i++) begin
        pl_r[i] <= pl_r[i-1];
      end
    end
  end

  // Decode the angles into the frame register when the tail byte arrives.
  always_ff @(posedge clk) begin
    if (in_acc && pos_r == POS_TAIL) begin
      fr_tail_ok_r <= (in_ch.rx_byte == TAIL_BYTE);
      fr_ang_r[0]  <= {pl_r[5], pl_r[4]};
      fr_ang_r[1]  <= {pl_r[3], pl_r[2]};
      fr_ang_r[2]  <= {pl_r[1], pl_r[0]};
    end
  end

  // Range and jump checks plus the filter candidates.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ang_abs[i]  = abs17((ANGLE_W+1)'(fr_ang_r[i]));
      jump_abs[i] = abs17((ANGLE_W+1)'(fr_ang_r[i]) - (ANGLE_W+1)'(last_r[i]));
      sm_upd[i]   = filt_step(sm_r[i], fr_ang_r[i], alpha_r);
    end
    range_bad = (ang_abs[0] > (ANGLE_W+1)'(yaw_lim_r))
             || (ang_abs[1] > (ANGLE_W+1)'(tilt_lim_r))
             || (ang_abs[2] > (ANGLE_W+1)'(tilt_lim_r));
    jump_bad  = (jump_abs[0] > (ANGLE_W+1)'(yaw_jump_r))
             || (jump_abs[1] > (ANGLE_W+1)'(tilt_jump_r))
             || (jump_abs[2] > (ANGLE_W+1)'(tilt_jump_r));
    if (!fr_tail_ok_r) begin
      status = ST_BAD_TAIL;
    end else if (range_bad) begin
      status = ST_RANGE;
    end else if (jump_bad) begin
      status = ST_JUMP;
    end else begin
      status = ST_ACCEPT;
    end
  end

  // Filter state moves only on an accepted frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        last_r[i] <= '0;
        sm_r[i]   <= '0;
      end
    end else if (fire && status == ST_ACCEPT) begin
      for (int i = 0; i < 3; i++) begin
        last_r[i] <= fr_ang_r[i];
        sm_r[i]   <= sm_upd[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= status;
      for (int i = 0; i < 3; i++) begin
        out_ang_r[i] <= fr_ang_r[i];
        out_sm_r[i]  <= (status == ST_ACCEPT) ? sm_upd[i] : sm_r[i];
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_status   = out_status_r;
  assign out_ch.yaw_sample     = out_ang_r[0];
  assign out_ch.pitch_sample   = out_ang_r[1];
  assign out_ch.roll_sample    = out_ang_r[2];
  assign out_ch.yaw_smoothed   = out_sm_r[0];
  assign out_ch.pitch_smoothed = out_sm_r[1];
  assign out_ch.roll_smoothed  = out_sm_r[2];

  // A tail byte always hands a frame on and restarts the header search.
  `IAFF_ASSERT_NEXT(a_tail_loads, in_acc && pos_r == POS_TAIL, fr_valid_r && pos_r == POS_HEADER)
  // The input only stalls behind a waiting frame.
  `IAFF_ASSERT_NOW(a_stall_cause, !in_ch.ready, fr_valid_r && out_valid_r)
  // A shown result's yaw and roll smoothed angles always match the current filter state.
  `IAFF_ASSERT_NOW(a_sm_match, out_valid_r, out_sm_r[0] == sm_r[0] && out_sm_r[2] == sm_r[2])
  // An accepted result's yaw and pitch angles are the last accepted angles.
  `IAFF_ASSERT_NOW(a_last_match, out_valid_r && out_status_r == ST_ACCEPT,
                   out_ang_r[0] == last_r[0] && out_ang_r[1] == last_r[1])

endmodule
